/* rtl/core/tbct_pkg.sv */
// Package for the triangle/box collision test: field types, widths and the
// beat payload struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbct_pkg;

  localparam int COORD_W = 16;  // signed Q11.4 coordinate
  localparam int SIZE_W  = 14;  // unsigned Q10.4 size / radius
  localparam int DIFF_W  = 19;  // doubled center difference, signed
  localparam int SQ_W    = 37;  // square of a doubled difference
  localparam int RS_W    = 16;  // doubled radius sum
  localparam int SUM_W   = 38;  // sum of two squares

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [SIZE_W-1:0]  size_t;

  typedef struct packed {
    coord_t box_left;
    coord_t box_top;
    size_t  box_width;
    size_t  box_height;
    size_t  box_radius;
    coord_t base_a_x;
    coord_t base_a_y;
    coord_t base_b_x;
    coord_t base_b_y;
    coord_t apex_x;
    coord_t apex_y;
    size_t  tri_radius;
  } pair_t;

endpackage

`default_nettype wire

/* rtl/core/tbct_if.sv */
// Valid/ready channel interfaces for the collision test: object pair in,
// verdict out. Depends on tbct_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tbct_in_if
  import tbct_pkg::*;
  ;
  logic   valid;
  logic   ready;
  coord_t box_left;
  coord_t box_top;
  size_t  box_width;
  size_t  box_height;
  size_t  box_radius;
  coord_t base_a_x;
  coord_t base_a_y;
  coord_t base_b_x;
  coord_t base_b_y;
  coord_t apex_x;
  coord_t apex_y;
  size_t  tri_radius;

  modport source (
    output valid, box_left, box_top, box_width, box_height, box_radius,
           base_a_x, base_a_y, base_b_x, base_b_y, apex_x, apex_y, tri_radius,
    input  ready
  );
  modport sink (
    input  valid, box_left, box_top, box_width, box_height, box_radius,
           base_a_x, base_a_y, base_b_x, base_b_y, apex_x, apex_y, tri_radius,
    output ready
  );
endinterface

interface tbct_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic broad_hit;

  modport source (output valid, hit, broad_hit, input ready);
  modport sink   (input valid, hit, broad_hit, output ready);
endinterface

`default_nettype wire

/* rtl/core/tbct_broad.sv */
// Broad phase: squared center distance against squared radius sum.
// Squares registered on ld, compare is combinational. Depends on tbct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbct_broad
  import tbct_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  ld,
  input  wire pair_t item,
  output logic       broad
);

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [SUM_W-1:0]  dx_sq;
  logic signed [SUM_W-1:0]  dy_sq;
  logic [SIZE_W:0]          rad_sum;
  logic [RS_W-1:0]          rs;
  logic [SQ_W-1:0]          sqx_r;
  logic [SQ_W-1:0]          sqy_r;
  logic [2*RS_W-1:0]        rs2_r;

  // Centers kept doubled so no rounding is needed.
  always_comb begin
    dx = (DIFF_W'(item.box_left) <<< 1) + DIFF_W'(item.box_width)
         - DIFF_W'(item.base_a_x) - DIFF_W'(item.base_b_x);
    dy = (DIFF_W'(item.box_top) <<< 1) + DIFF_W'(item.box_height)
         - DIFF_W'(item.base_a_y) - DIFF_W'(item.base_b_y);
    dx_sq   = SUM_W'(dx) * SUM_W'(dx);
    dy_sq   = SUM_W'(dy) * SUM_W'(dy);
    rad_sum = (SIZE_W+1)'(item.box_radius) + (SIZE_W+1)'(item.tri_radius);
    rs      = {rad_sum, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      sqx_r <= dx_sq[SQ_W-1:0];
      sqy_r <= dy_sq[SQ_W-1:0];
      rs2_r <= (2*RS_W)'(rs) * (2*RS_W)'(rs);
    end
  end

  // Strict: touching circles do not count.
  assign broad = (SUM_W'(sqx_r) + SUM_W'(sqy_r)) < SUM_W'(rs2_r);

endmodule

`default_nettype wire

/* rtl/core/tbct_narrow.sv */
// Narrow phase: edge samples tested against the half-open box.
// Scaled numerators and bounds registered on ld. Depends on tbct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbct_narrow
  import tbct_pkg::*;
#(
  parameter int POINTS_PER_EDGE = 7
) (
  input  wire logic  clk,
  input  wire logic  ld,
  input  wire pair_t item,
  output logic       narrow
);

  // floor(n/N) in [lo, hi) is n in [N*lo, N*hi): no divide needed.
  localparam int CW = 18 + $clog2(POINTS_PER_EDGE);
  localparam int NS = POINTS_PER_EDGE - 1;  // samples per edge, start point incl.

  coord_t vx [3];
  coord_t vy [3];

  logic signed [CW-1:0] num_x_r [3][NS];
  logic signed [CW-1:0] num_y_r [3][NS];
  logic signed [CW-1:0] lo_x_r;
  logic signed [CW-1:0] hi_x_r;
  logic signed [CW-1:0] lo_y_r;
  logic signed [CW-1:0] hi_y_r;
  logic [3*NS-1:0]      in_box;

  always_comb begin
    vx[0] = item.base_a_x;
    vy[0] = item.base_a_y;
    vx[1] = item.base_b_x;
    vy[1] = item.base_b_y;
    vx[2] = item.apex_x;
    vy[2] = item.apex_y;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      lo_x_r <= CW'(POINTS_PER_EDGE) * CW'(item.box_left);
      hi_x_r <= CW'(POINTS_PER_EDGE) * (CW'(item.box_left) + CW'(item.box_width));
      lo_y_r <= CW'(POINTS_PER_EDGE) * CW'(item.box_top);
      hi_y_r <= CW'(POINTS_PER_EDGE) * (CW'(item.box_top) + CW'(item.box_height));
    end
  end

  // Edge e runs from vertex e to vertex e+1; its end point is the next
  // edge's start point.
  for (genvar e = 0; e < 3; e++) begin : g_edge
    for (genvar i = 0; i < NS; i++) begin : g_pt
      always_ff @(posedge clk) begin
        if (ld) begin
          num_x_r[e][i] <= CW'(i) * CW'(vx[(e+1)%3])
                           + CW'(POINTS_PER_EDGE - i) * CW'(vx[e]);
          num_y_r[e][i] <= CW'(i) * CW'(vy[(e+1)%3])
                           + CW'(POINTS_PER_EDGE - i) * CW'(vy[e]);
        end
      end

      assign in_box[e*NS+i] = (num_x_r[e][i] >= lo_x_r) && (num_x_r[e][i] < hi_x_r)
                           && (num_y_r[e][i] >= lo_y_r) && (num_y_r[e][i] < hi_y_r);
    end
  end

  assign narrow = |in_box;

endmodule

`default_nettype wire

/* rtl/core/triangle_box_collision_test_unit.sv */
// Top level of the triangle/box collision test: input register, broad and
// narrow phase units, result register. Depends on tbct_pkg, tbct_if,
// tbct_broad and tbct_narrow.
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  beat payload
// --------  ---  ---------------------------------------------------------
// in_bus    in   box (left, top, width, height, radius), triangle corners,
//                triangle radius
// out_bus   out  hit, broad_hit
//
// Three register stages: input register, phase registers (squares, scaled
// sample numerators), result register. out_bus.valid rises once a pair has
// passed the input register, the phase registers and the result register;
// one pair per cycle sustained while out_bus.ready stays high.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// are squeezed out and in_bus.ready can stay high while a result waits.
// Reset (rst_n, synchronous) clears the stage valid bits only.

module triangle_box_collision_test_unit
  import tbct_pkg::*;
#(
  parameter int POINTS_PER_EDGE = 7
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  tbct_in_if.sink      in_bus,
  tbct_out_if.source   out_bus
);

  pair_t item_r;
  logic  v0_r, v0_nxt;
  logic  v1_r, v1_nxt;
  logic  ov_r, ov_nxt;
  logic  hit_r;
  logic  broad_hit_r;

  logic  ld0, ld1, ld2;
  logic  broad;
  logic  narrow;

  // stage load enables, back to front
  assign ld2 = !ov_r || out_bus.ready;
  assign ld1 = !v1_r || ld2;
  assign ld0 = !v0_r || ld1;

  assign in_bus.ready = ld0;

  always_comb begin
    v0_nxt = ld0 ? in_bus.valid : v0_r;
    v1_nxt = ld1 ? v0_r : v1_r;
    ov_nxt = ld2 ? v1_r : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      ov_r <= ov_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (ld0 && in_bus.valid) begin
      item_r.box_left   <= in_bus.box_left;
      item_r.box_top    <= in_bus.box_top;
      item_r.box_width  <= in_bus.box_width;
      item_r.box_height <= in_bus.box_height;
      item_r.box_radius <= in_bus.box_radius;
      item_r.base_a_x   <= in_bus.base_a_x;
      item_r.base_a_y   <= in_bus.base_a_y;
      item_r.base_b_x   <= in_bus.base_b_x;
      item_r.base_b_y   <= in_bus.base_b_y;
      item_r.apex_x     <= in_bus.apex_x;
      item_r.apex_y     <= in_bus.apex_y;
      item_r.tri_radius <= in_bus.tri_radius;
    end
  end

  tbct_broad u_broad (
    .clk   (clk),
    .ld    (ld1),
    .item  (item_r),
    .broad (broad)
  );

  tbct_narrow #(
    .POINTS_PER_EDGE (POINTS_PER_EDGE)
  ) u_narrow (
    .clk    (clk),
    .ld     (ld1),
    .item   (item_r),
    .narrow (narrow)
  );

  // result register; a broad miss masks the narrow phase
  always_ff @(posedge clk) begin
    if (ld2) begin
      hit_r       <= broad && narrow;
      broad_hit_r <= broad;
    end
  end

  assign out_bus.valid     = ov_r;
  assign out_bus.hit       = hit_r;
  assign out_bus.broad_hit = broad_hit_r;

endmodule

`default_nettype wire
